// ===== rtl/deflate_stored_block_packer_defines.svh =====
// Assertion macros for the stored-block packer.
`ifndef DEFLATE_STORED_BLOCK_PACKER_DEFINES_SVH
`define DEFLATE_STORED_BLOCK_PACKER_DEFINES_SVH

// A property that must hold in the same cycle as its trigger.
`define DSBP_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// A property that must hold in the cycle after its trigger.
`define DSBP_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/dsbp_pkg.sv =====
// Types, constants and header helper shared by the stored-block packer.
package dsbp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HDR  = 3'b010,
      ST_DATA = 3'b100
   } state_type;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Header bytes are numbered 0 to 4.
   localparam logic [2:0] HDR_LAST = 3'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       block_last;
   } out_item_type;

   // One byte of the five-byte stored-block header.
   function automatic logic [7:0] header_byte(input logic [2:0] idx,
                                              input logic final_flag,
                                              input logic [15:0] len);
      logic [15:0] nlen;
      logic [7:0]  result;
      nlen = ~len;
      unique case (idx)
         3'd0:    result = {7'b0, final_flag};
         3'd1:    result = len[7:0];
         3'd2:    result = len[15:8];
         3'd3:    result = nlen[7:0];
         3'd4:    result = nlen[15:8];
         default: result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/dsbp_out_reg.sv =====
// Output holding register for result items with a valid and ready handshake.
module dsbp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dsbp_pkg::out_item_type load_item,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dsbp_pkg::out_item_type rsp_item
);

   logic                   valid_ff;
   logic                   valid_in;
   dsbp_pkg::out_item_type item_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

// ===== rtl/deflate_stored_block_packer.sv =====
// Data item: written to the block buffer, no result unless it fills the buffer.
// The item that closes a block moves the packer to its header state, from which the first
// header byte is loaded into the output register; then one byte per cycle while rsp_ready
// is high, 5 + LEN bytes per block. Input is held off while a block drains.
// Reset clears state, fill count and output valid; buffer contents stay unwritten.
module deflate_stored_block_packer #(
   parameter int BLOCK_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_block_last
);

   `include "deflate_stored_block_packer_defines.svh"

   localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int FW = $clog2(BLOCK_BYTES + 1);

   dsbp_pkg::state_type state_ff, state_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [FW-1:0]       len_ff, len_in;
   logic                final_ff, final_in;
   logic [2:0]          hcnt_ff, hcnt_in;
   logic [AW-1:0]       idx_ff, idx_in;

   logic [7:0]          mem [BLOCK_BYTES];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   logic                   out_load;
   logic                   out_free;
   dsbp_pkg::out_item_type out_item;
   dsbp_pkg::out_item_type rsp_item;
   logic                   data_is_last;

   assign req_ready      = (state_ff == dsbp_pkg::ST_IDLE);
   assign rsp_out_byte   = rsp_item.out_byte;
   assign rsp_block_last = rsp_item.block_last;
   assign data_is_last   = ((FW'(idx_ff) + FW'(1)) == len_ff);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      final_in = final_ff;
      hcnt_in  = hcnt_ff;
      idx_in   = idx_ff;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      out_load = 1'b0;
      out_item.out_byte   = rd_data_ff;
      out_item.block_last = 1'b0;
      unique case (state_ff)
         dsbp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == dsbp_pkg::OP_FINISH) begin
                  len_in   = fill_ff;
                  final_in = 1'b1;
                  fill_in  = '0;
                  hcnt_in  = '0;
                  state_in = dsbp_pkg::ST_HDR;
               end else begin
                  mem_we = 1'b1;
                  if ((fill_ff + FW'(1)) == FW'(BLOCK_BYTES)) begin
                     len_in   = FW'(BLOCK_BYTES);
                     final_in = 1'b0;
                     fill_in  = '0;
                     hcnt_in  = '0;
                     state_in = dsbp_pkg::ST_HDR;
                  end else begin
                     fill_in = fill_ff + FW'(1);
                  end
               end
            end
         end
         dsbp_pkg::ST_HDR: begin
            if (out_free) begin
               out_load = 1'b1;
               out_item.out_byte = dsbp_pkg::header_byte(hcnt_ff, final_ff, 16'(len_ff));
               out_item.block_last = (hcnt_ff == dsbp_pkg::HDR_LAST) && (len_ff == '0);
               if (hcnt_ff == dsbp_pkg::HDR_LAST) begin
                  if (len_ff == '0) begin
                     state_in = dsbp_pkg::ST_IDLE;
                  end else begin
                     // Fetch the first buffered byte while the last header byte goes out.
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = dsbp_pkg::ST_DATA;
                  end
               end else begin
                  hcnt_in = hcnt_ff + 3'd1;
               end
            end
         end
         dsbp_pkg::ST_DATA: begin
            if (out_free) begin
               out_load = 1'b1;
               out_item.block_last = data_is_last;
               if (data_is_last) begin
                  state_in = dsbp_pkg::ST_IDLE;
               end else begin
                  // The read data register holds until the byte it carries is taken.
                  idx_in  = idx_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = dsbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsbp_pkg::ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      final_ff <= final_in;
      hcnt_ff  <= hcnt_in;
      idx_ff   <= idx_in;
   end

   // Writes happen only while idle and reads only while draining, so they never collide.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[AW-1:0]] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   dsbp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_item (out_item),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `DSBP_ASSERT_SAME(a_fill_below_block, clock, reset,
      state_ff == dsbp_pkg::ST_IDLE, fill_ff < FW'(BLOCK_BYTES),
      "fill count reached block size while idle")
   `DSBP_ASSERT_NEXT(a_finish_starts_header, clock, reset,
      req_valid && req_ready && (req_opcode == dsbp_pkg::OP_FINISH),
      (state_ff == dsbp_pkg::ST_HDR) && final_ff && (fill_ff == '0),
      "finish item did not start a final block")
   `DSBP_ASSERT_SAME(a_data_index_in_range, clock, reset,
      state_ff == dsbp_pkg::ST_DATA, FW'(idx_ff) < len_ff,
      "data index ran past block length")

endmodule

// ===== tb/sv/tb_deflate_stored_block_packer.sv =====
// Self-checking testbench for the DEFLATE stored-block packer, with its own stream predictor.
`timescale 1ns / 100ps

module tb_deflate_stored_block_packer;

   localparam int BLOCK_BYTES    = 32;
   localparam int RANDOM_ITEMS   = 500;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_CADENCE
   } ready_mode_type;

   typedef struct {
      logic       opcode;
      logic [7:0] data_byte;
      bit         drain_first;
   } byte_cmd_type;

   logic       clock;
   logic       reset;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic       req_opcode    = dsbp_pkg::OP_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_block_last;

   byte_cmd_type           cmd_queue[$];
   dsbp_pkg::out_item_type due_bytes[$];

   // Predictor state: a copy of the block buffer and its fill level.
   logic [7:0]     block_copy[BLOCK_BYTES];
   logic [5:0]     fill_level = 6'd0;

   int             error_count = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             idle_cycles = 0;
   int             mode_left = 0;
   int             cadence = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic           present_next;
   logic           ready_next;

   deflate_stored_block_packer #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_block_last(rsp_block_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void push_stream_byte(input logic [7:0] value, input logic last);
      dsbp_pkg::out_item_type beat;
      beat.out_byte   = value;
      beat.block_last = last;
      due_bytes.push_back(beat);
   endfunction

   // Header is BFINAL, LEN low/high, NLEN low/high, then the buffered bytes.
   function automatic void emit_stored_block(input logic final_flag);
      logic [15:0] len;
      logic [15:0] nlen;
      int          i;
      len  = (fill_level > BLOCK_BYTES) ? 16'(BLOCK_BYTES) : 16'(fill_level);
      nlen = ~len;
      push_stream_byte({7'b0, final_flag}, 1'b0);
      push_stream_byte(len[7:0], 1'b0);
      push_stream_byte(len[15:8], 1'b0);
      push_stream_byte(nlen[7:0], 1'b0);
      push_stream_byte(nlen[15:8], len == 16'd0);
      for (i = 0; i < int'(len); i++)
         push_stream_byte(block_copy[i], i == int'(len) - 1);
      fill_level = 6'd0;
   endfunction

   function automatic void pack_item(input logic opcode, input logic [7:0] data_byte);
      if (opcode == dsbp_pkg::OP_FINISH) begin
         emit_stored_block(1'b1);
      end else begin
         if (fill_level < BLOCK_BYTES) begin
            block_copy[fill_level] = data_byte;
            fill_level = fill_level + 6'd1;
         end
         if (fill_level >= BLOCK_BYTES)
            emit_stored_block(1'b0);
      end
   endfunction

   function automatic void queue_cmd(input logic opcode, input logic [7:0] data_byte,
                                     input bit drain_first);
      byte_cmd_type cmd;
      cmd.opcode      = opcode;
      cmd.data_byte   = data_byte;
      cmd.drain_first = drain_first;
      cmd_queue.push_back(cmd);
   endfunction

   // Driver: bursts of items separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else begin
         present_next = req_valid && !req_ready;
         if (req_valid && req_ready)
            pack_item(req_opcode, req_data_byte);
         if (!present_next) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].drain_first && due_bytes.size() != 0)) begin
               req_opcode    <= cmd_queue[0].opcode;
               req_data_byte <= cmd_queue[0].data_byte;
               void'(cmd_queue.pop_front());
               present_next = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_valid <= present_next;
      end
   end

   // Receiver: switches at random between stall patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_mode <= READY_ALWAYS;
         mode_left  <= 50;
         cadence    <= 0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         cadence <= (cadence == 4) ? 0 : cadence + 1;
         case (ready_mode)
            READY_ALWAYS:  ready_next = 1'b1;
            READY_MOSTLY:  ready_next = ($urandom_range(0, 3) != 0);
            READY_RARELY:  ready_next = ($urandom_range(0, 3) == 0);
            default:       ready_next = (cadence < 3);
         endcase
         rsp_ready <= ready_next;
      end
   end

   // Monitor: every accepted byte is checked against the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_bytes.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < REPORT_LIMIT)
               $display("unexpected byte: out_byte=%02h block_last=%0b",
                        rsp_out_byte, rsp_block_last);
         end else begin
            if (rsp_out_byte !== due_bytes[0].out_byte ||
                rsp_block_last !== due_bytes[0].block_last) begin
               error_count <= error_count + 1;
               if (error_count < REPORT_LIMIT)
                  $display("mismatch: out_byte exp %02h got %02h, block_last exp %0b got %0b",
                           due_bytes[0].out_byte, rsp_out_byte,
                           due_bytes[0].block_last, rsp_block_last);
            end
            void'(due_bytes.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL deflate_stored_block_packer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_items;
      int run_len;
      int k;
      random_items = 0;

      // Directed: empty final block, extreme bytes, finish with a nonzero ignored byte.
      queue_cmd(dsbp_pkg::OP_FINISH, 8'h00, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h00, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'hFF, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h80, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h01, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h7F, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'hAA, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h55, 1'b0);
      queue_cmd(dsbp_pkg::OP_FINISH, 8'hFF, 1'b0);
      queue_cmd(dsbp_pkg::OP_FINISH, 8'hA5, 1'b0);
      queue_cmd(dsbp_pkg::OP_DATA, 8'h3C, 1'b1);
      queue_cmd(dsbp_pkg::OP_FINISH, 8'h00, 1'b0);

      // Random streams of varied length, each closed by a finish.
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    run_len = $urandom_range(0, 5);
            2, 3, 4: run_len = $urandom_range(6, 31);
            5:       run_len = BLOCK_BYTES;
            6:       run_len = ($urandom_range(0, 1) == 0) ? BLOCK_BYTES - 1 : BLOCK_BYTES + 1;
            7:       run_len = 2 * BLOCK_BYTES;
            default: run_len = $urandom_range(BLOCK_BYTES + 1, 70);
         endcase
         for (k = 0; k < run_len; k++)
            queue_cmd(dsbp_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                      random_items + k == 0 || $urandom_range(0, 59) == 0);
         queue_cmd(dsbp_pkg::OP_FINISH, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 29) == 0);
         random_items += run_len + 1;
      end

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (due_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("PASS deflate_stored_block_packer");
      else
         $display("FAIL deflate_stored_block_packer");
      $finish;
   end

endmodule
